/* rtl/egsel_pkg.sv */
// Shared constants and controller/datapath interface types for the epsilon-greedy selector.
package egsel_pkg;

   localparam int NUM_ACTIONS  = 8;
   localparam int VALUE_BITS   = 16;
   localparam int EST_W        = 16;
   localparam int DRAW_W       = 16;
   localparam int EPS_W        = 7;
   localparam int ACT_W        = 3;
   localparam int TIE_W        = 4;
   localparam int PERCENT_BASE = 100;

   localparam int IDX_W   = $clog2(NUM_ACTIONS);
   localparam int POS_W   = $clog2(NUM_ACTIONS + 1);
   localparam int PCT_W   = $clog2(PERCENT_BASE + 1);
   localparam int DIV_W   = POS_W;
   localparam int CNT_W   = $clog2(DRAW_W);

   // draw / 100 as (draw * ceil(2^23 / 100)) >> 23, exact for every 16-bit draw
   localparam int PCT_MUL_W = 17;
   localparam int PCT_SHIFT = 23;
   localparam int QUOT_W    = 10;
   localparam int PROD_W    = DRAW_W + PCT_MUL_W;
   localparam logic [PCT_MUL_W-1:0] PCT_MUL = PCT_MUL_W'(83887);

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(10);
   localparam logic [31:0] VALUE_MAX = 32'((64'd1 << VALUE_BITS) - 64'd1);

   typedef enum logic [1:0] {
      MOD_ACTION,
      MOD_TIE
   } mod_sel_type;

   typedef struct packed {
      logic        take;
      logic        mod_start;
      mod_sel_type mod_sel;
      logic        latch_explore;
      logic        act_rem;
      logic        scan_init;
      logic        scan_step;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic mod_busy;
      logic explore_hit;
      logic ties_multi;
      logic scan_found;
      logic scan_end;
      logic out_free;
   } status_type;

endpackage

/* rtl/egsel_mod.sv */
// Iterative restoring remainder unit: one dividend bit per cycle.
module egsel_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [egsel_pkg::DRAW_W-1:0]  dividend,
   input  logic [egsel_pkg::DIV_W-1:0]   divisor,
   output logic                          busy,
   output logic [egsel_pkg::DIV_W-1:0]   remainder
);

   logic                          busy_ff, busy_in;
   logic [egsel_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [egsel_pkg::DRAW_W-1:0]  shift_ff, shift_in;
   logic [egsel_pkg::DIV_W-1:0]   divisor_ff, divisor_in;
   logic [egsel_pkg::DIV_W-1:0]   rem_ff, rem_in;
   logic [egsel_pkg::DIV_W:0]     trial;
   logic [egsel_pkg::DIV_W:0]     diff;

   // rem < divisor, so trial < 2*divisor and the difference fits DIV_W bits
   assign trial = {rem_ff, shift_ff[egsel_pkg::DRAW_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         shift_in   = dividend;
         divisor_in = divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[egsel_pkg::DRAW_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[egsel_pkg::DIV_W-1:0];
         end else begin
            rem_in = trial[egsel_pkg::DIV_W-1:0];
         end
         count_in = count_ff + egsel_pkg::CNT_W'(1);
         if (count_ff == egsel_pkg::CNT_W'(egsel_pkg::DRAW_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/egsel_datapath.sv */
// Datapath: running maximum and tie tracking, draw registers, tie scan, result register.
module egsel_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  egsel_pkg::cmd_type                cmd,
   output egsel_pkg::status_type             status,
   input  logic [egsel_pkg::EST_W-1:0]       estimate,
   input  logic                              last_estimate,
   input  logic [egsel_pkg::DRAW_W-1:0]      explore_draw,
   input  logic [egsel_pkg::DRAW_W-1:0]      action_draw,
   input  logic [egsel_pkg::DRAW_W-1:0]      tie_draw,
   input  logic                              csr_write,
   input  logic [egsel_pkg::EPS_W-1:0]       csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [egsel_pkg::ACT_W-1:0]       rsp_chosen_action,
   output logic                              rsp_explored,
   output logic [egsel_pkg::TIE_W-1:0]       rsp_tie_count
);

   logic [egsel_pkg::EPS_W-1:0]       epsilon_ff, epsilon_in;
   logic [egsel_pkg::VALUE_BITS-1:0]  best_value_ff, best_value_in;
   logic [egsel_pkg::IDX_W-1:0]       best_index_ff, best_index_in;
   logic [egsel_pkg::NUM_ACTIONS-1:0] tied_mask_ff, tied_mask_in;
   logic [egsel_pkg::POS_W-1:0]       ties_seen_ff, ties_seen_in;
   logic [egsel_pkg::POS_W-1:0]       position_ff, position_in;
   logic [egsel_pkg::DRAW_W-1:0]      explore_draw_ff, explore_draw_in;
   logic [egsel_pkg::DRAW_W-1:0]      action_draw_ff, action_draw_in;
   logic [egsel_pkg::DRAW_W-1:0]      tie_draw_ff, tie_draw_in;
   logic                              explored_ff, explored_in;
   logic [egsel_pkg::IDX_W-1:0]       action_ff, action_in;
   logic [egsel_pkg::IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [egsel_pkg::DIV_W-1:0]       scan_k_ff, scan_k_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [egsel_pkg::ACT_W-1:0]       rsp_action_ff, rsp_action_in;
   logic                              rsp_explored_ff, rsp_explored_in;
   logic [egsel_pkg::TIE_W-1:0]       rsp_ties_ff, rsp_ties_in;
   logic [egsel_pkg::QUOT_W-1:0]      pct_quot_ff, pct_quot_in;

   logic [31:0]                       est_wide;
   logic [egsel_pkg::VALUE_BITS-1:0]  est_sat;
   logic [egsel_pkg::IDX_W-1:0]       pos_idx;
   logic [egsel_pkg::NUM_ACTIONS-1:0] pos_bit;
   logic [egsel_pkg::POS_W-1:0]       action_count;
   logic [egsel_pkg::DRAW_W-1:0]      mod_dividend;
   logic [egsel_pkg::DIV_W-1:0]       mod_divisor;
   logic                              mod_busy;
   logic [egsel_pkg::DIV_W-1:0]       mod_rem;
   logic [31:0]                       action_wide;
   logic [31:0]                       ties_wide;
   logic [egsel_pkg::PROD_W-1:0]      pct_prod;
   logic [egsel_pkg::DRAW_W-1:0]      pct_back;
   logic [egsel_pkg::DRAW_W-1:0]      pct_diff;
   logic [egsel_pkg::PCT_W-1:0]       pct_rem;

   assign est_wide = 32'(estimate);
   assign est_sat  = (est_wide > egsel_pkg::VALUE_MAX) ?
                     egsel_pkg::VALUE_MAX[egsel_pkg::VALUE_BITS-1:0] :
                     est_wide[egsel_pkg::VALUE_BITS-1:0];
   assign pos_idx  = position_ff[egsel_pkg::IDX_W-1:0];
   assign pos_bit  = egsel_pkg::NUM_ACTIONS'(1) << pos_idx;
   assign action_count = (position_ff == '0) ? egsel_pkg::POS_W'(1) : position_ff;

   // explore draw mod 100: the quotient is registered from the held draw, in the cycle after the draw is taken
   assign pct_prod    = egsel_pkg::PROD_W'(explore_draw_ff) *
                        egsel_pkg::PROD_W'(egsel_pkg::PCT_MUL);
   assign pct_quot_in = pct_prod[egsel_pkg::PCT_SHIFT +: egsel_pkg::QUOT_W];
   assign pct_back    = egsel_pkg::DRAW_W'(pct_quot_ff) *
                        egsel_pkg::DRAW_W'(egsel_pkg::PERCENT_BASE);
   assign pct_diff    = explore_draw_ff - pct_back;
   assign pct_rem     = pct_diff[egsel_pkg::PCT_W-1:0];

   always_comb begin
      case (cmd.mod_sel)
         egsel_pkg::MOD_ACTION: begin
            mod_dividend = action_draw_ff;
            mod_divisor  = egsel_pkg::DIV_W'(action_count);
         end
         egsel_pkg::MOD_TIE: begin
            mod_dividend = tie_draw_ff;
            mod_divisor  = egsel_pkg::DIV_W'(ties_seen_ff);
         end
         default: begin
            mod_dividend = action_draw_ff;
            mod_divisor  = egsel_pkg::DIV_W'(action_count);
         end
      endcase
   end

   egsel_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   always_comb begin
      epsilon_in      = epsilon_ff;
      best_value_in   = best_value_ff;
      best_index_in   = best_index_ff;
      tied_mask_in    = tied_mask_ff;
      ties_seen_in    = ties_seen_ff;
      position_in     = position_ff;
      explore_draw_in = explore_draw_ff;
      action_draw_in  = action_draw_ff;
      tie_draw_in     = tie_draw_ff;
      explored_in     = explored_ff;
      action_in       = action_ff;
      scan_idx_in     = scan_idx_ff;
      scan_k_in       = scan_k_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_action_in   = rsp_action_ff;
      rsp_explored_in = rsp_explored_ff;
      rsp_ties_in     = rsp_ties_ff;

      if (csr_write) begin
         epsilon_in = csr_data;
      end

      if (cmd.take) begin
         if (last_estimate) begin
            explore_draw_in = explore_draw;
            action_draw_in  = action_draw;
            tie_draw_in     = tie_draw;
         end
         // estimates past the last action slot are dropped
         if (position_ff < egsel_pkg::POS_W'(egsel_pkg::NUM_ACTIONS)) begin
            if (position_ff == '0 || est_sat > best_value_ff) begin
               best_value_in = est_sat;
               best_index_in = pos_idx;
               tied_mask_in  = pos_bit;
               ties_seen_in  = egsel_pkg::POS_W'(1);
            end else if (est_sat == best_value_ff) begin
               tied_mask_in = tied_mask_ff | pos_bit;
               ties_seen_in = ties_seen_ff + egsel_pkg::POS_W'(1);
            end
            position_in = position_ff + egsel_pkg::POS_W'(1);
         end
      end

      if (cmd.latch_explore) begin
         explored_in = status.explore_hit;
         action_in   = best_index_ff;
      end

      if (cmd.act_rem) begin
         action_in = egsel_pkg::IDX_W'(mod_rem);
      end

      if (cmd.scan_init) begin
         scan_idx_in = '0;
         scan_k_in   = mod_rem;
      end

      if (cmd.scan_step) begin
         if (tied_mask_ff[scan_idx_ff]) begin
            if (scan_k_ff == '0) begin
               action_in = scan_idx_ff;
            end else begin
               scan_k_in = scan_k_ff - egsel_pkg::DIV_W'(1);
            end
         end
         scan_idx_in = scan_idx_ff + egsel_pkg::IDX_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_action_in   = action_wide[egsel_pkg::ACT_W-1:0];
         rsp_explored_in = explored_ff;
         rsp_ties_in     = ties_wide[egsel_pkg::TIE_W-1:0];
         best_value_in   = '0;
         best_index_in   = '0;
         tied_mask_in    = '0;
         ties_seen_in    = '0;
         position_in     = '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign action_wide = 32'(action_ff);
   assign ties_wide   = 32'(ties_seen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff    <= egsel_pkg::EPS_RESET;
         best_value_ff <= '0;
         best_index_ff <= '0;
         tied_mask_ff  <= '0;
         ties_seen_ff  <= '0;
         position_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         epsilon_ff    <= epsilon_in;
         best_value_ff <= best_value_in;
         best_index_ff <= best_index_in;
         tied_mask_ff  <= tied_mask_in;
         ties_seen_ff  <= ties_seen_in;
         position_ff   <= position_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      explore_draw_ff <= explore_draw_in;
      action_draw_ff  <= action_draw_in;
      tie_draw_ff     <= tie_draw_in;
      explored_ff     <= explored_in;
      action_ff       <= action_in;
      scan_idx_ff     <= scan_idx_in;
      scan_k_ff       <= scan_k_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_explored_ff <= rsp_explored_in;
      rsp_ties_ff     <= rsp_ties_in;
      pct_quot_ff     <= pct_quot_in;
   end

   assign status.mod_busy    = mod_busy;
   assign status.explore_hit = pct_rem < epsilon_ff;
   assign status.ties_multi  = ties_seen_ff > egsel_pkg::POS_W'(1);
   assign status.scan_found  = tied_mask_ff[scan_idx_ff] && (scan_k_ff == '0);
   assign status.scan_end    = scan_idx_ff == egsel_pkg::IDX_W'(egsel_pkg::NUM_ACTIONS - 1);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_action = rsp_action_ff;
   assign rsp_explored      = rsp_explored_ff;
   assign rsp_tie_count     = rsp_ties_ff;

endmodule

/* rtl/egsel_ctrl.sv */
// Controller: sequences estimate intake, the explore test, the remainder steps, the tie scan and the result.
module egsel_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_estimate,
   output logic                   req_stall,
   input  egsel_pkg::status_type  status,
   output egsel_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      IDLE,
      EXP_GO,
      EXP_WAIT,
      ACT_GO,
      ACT_WAIT,
      TIE_GO,
      TIE_WAIT,
      SCAN,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = state_ff != IDLE;
   assign accept    = req_valid && (state_ff == IDLE);

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.mod_sel       = egsel_pkg::MOD_ACTION;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.take = 1'b1;
               if (req_last_estimate) begin
                  state_in = EXP_GO;
               end
            end
         end
         EXP_GO: begin
            // datapath registers the draw / 100 quotient this cycle
            state_in = EXP_WAIT;
         end
         EXP_WAIT: begin
            cmd.latch_explore = 1'b1;
            if (status.explore_hit) begin
               state_in = ACT_GO;
            end else if (status.ties_multi) begin
               state_in = TIE_GO;
            end else begin
               state_in = EMIT;
            end
         end
         ACT_GO: begin
            cmd.mod_sel   = egsel_pkg::MOD_ACTION;
            cmd.mod_start = 1'b1;
            state_in      = ACT_WAIT;
         end
         ACT_WAIT: begin
            cmd.mod_sel = egsel_pkg::MOD_ACTION;
            if (!status.mod_busy) begin
               cmd.act_rem = 1'b1;
               state_in    = EMIT;
            end
         end
         TIE_GO: begin
            cmd.mod_sel   = egsel_pkg::MOD_TIE;
            cmd.mod_start = 1'b1;
            state_in      = TIE_WAIT;
         end
         TIE_WAIT: begin
            cmd.mod_sel = egsel_pkg::MOD_TIE;
            if (!status.mod_busy) begin
               cmd.scan_init = 1'b1;
               state_in      = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_found || status.scan_end) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/epsilon_greedy_argmax_select.sv */
// Epsilon-greedy action selector: top level joining controller and datapath.
//
// Feed one action-value estimate per transaction, action 0 first, and flag the final
// one with req_last_estimate; the three random words are sampled with that final
// transaction. A non-final estimate is taken with one saturate-and-compare against
// the running maximum. The final one starts a sequence: the explore test (draw mod 100
// by reciprocal multiply), a remainder by the action or tie count on a one-bit-per-cycle
// unit over the 16-bit draw, and for a pick among ties a scan of the tie mask at one
// action per cycle; the new result then waits for the output register to free up if
// it is still held. Input is stalled while that sequence runs; the result sits in an
// output register, so the next epoch's estimates are taken while it waits. Estimates
// beyond NUM_ACTIONS in one epoch are ignored.
// csr_epsilon_percent (reset 10) may be written whenever the block is idle; values
// above 100 always explore.
module epsilon_greedy_argmax_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [egsel_pkg::EST_W-1:0]   req_estimate,
   input  logic                          req_last_estimate,
   input  logic [egsel_pkg::DRAW_W-1:0]  req_explore_draw,
   input  logic [egsel_pkg::DRAW_W-1:0]  req_action_draw,
   input  logic [egsel_pkg::DRAW_W-1:0]  req_tie_draw,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [egsel_pkg::ACT_W-1:0]   rsp_chosen_action,
   output logic                          rsp_explored,
   output logic [egsel_pkg::TIE_W-1:0]   rsp_tie_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [egsel_pkg::EPS_W-1:0]   csr_epsilon_percent
);

   egsel_pkg::cmd_type    cmd;
   egsel_pkg::status_type status;

   assign csr_ready = 1'b1;

   egsel_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_last_estimate (req_last_estimate),
      .req_stall         (req_stall),
      .status            (status),
      .cmd               (cmd)
   );

   egsel_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .estimate          (req_estimate),
      .last_estimate     (req_last_estimate),
      .explore_draw      (req_explore_draw),
      .action_draw       (req_action_draw),
      .tie_draw          (req_tie_draw),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_epsilon_percent),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chosen_action (rsp_chosen_action),
      .rsp_explored      (rsp_explored),
      .rsp_tie_count     (rsp_tie_count)
   );

endmodule
